// ===== rtl/keyboard_scancode_line_editor_core_macros.svh =====
// ----------------------------------------------------------------------------
// keyboard scancode line editor assertion macros
// shared property shorthands for the checker, clocked on i_clk, off in reset
// ----------------------------------------------------------------------------
`ifndef KEYBOARD_SCANCODE_LINE_EDITOR_CORE_MACROS_SVH
`define KEYBOARD_SCANCODE_LINE_EDITOR_CORE_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define KSLE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define KSLE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/ksle_pkg.sv =====
// ----------------------------------------------------------------------------
// ksle_pkg
// shared types, codes and key maps of the scancode line editor
// ----------------------------------------------------------------------------
package ksle_pkg;

    localparam int OP_W    = 2;
    localparam int SC_W    = 8;
    localparam int IDX_W   = 10;
    localparam int KIND_W  = 2;
    localparam int CHAR_W  = 8;
    localparam int LEN_W   = 11;
    localparam int KEY_SPAN = 58;

    // input op codes
    localparam logic [OP_W-1:0] OP_SCAN  = 2'd0;
    localparam logic [OP_W-1:0] OP_READ  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_STATUS = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ECHO   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ERASE  = 2'd2;

    // set 1 make codes with a special meaning
    localparam logic [SC_W-1:0] SC_BACKSPACE = 8'd14;
    localparam logic [SC_W-1:0] SC_CAPS      = 8'd58;
    localparam logic [SC_W-1:0] SC_LSHIFT    = 8'd42;
    localparam logic [SC_W-1:0] SC_RSHIFT    = 8'd54;
    localparam logic [SC_W-1:0] SC_CTRL      = 8'd29;
    localparam logic [SC_W-1:0] SC_ENTER     = 8'd28;
    localparam int              RELEASE_BIT  = 7;

    localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0a;
    localparam logic [CHAR_W-1:0] CH_CARET   = 8'h5e;

    // table select
    localparam logic [1:0] MAP_PLAIN = 2'd0;
    localparam logic [1:0] MAP_UPPER = 2'd1;
    localparam logic [1:0] MAP_CTRL  = 2'd2;

    localparam logic [CHAR_W-1:0] PLAIN_MAP [KEY_SPAN] = '{
        8'h00, 8'h00, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38,
        8'h39, 8'h30, 8'h2d, 8'h3d, 8'h00, 8'h00,
        8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69, 8'h6f, 8'h70,
        8'h5b, 8'h5d, 8'h0a, 8'h00,
        8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6a, 8'h6b, 8'h6c, 8'h3b,
        8'h27, 8'h60, 8'h00, 8'h5c,
        8'h7a, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6e, 8'h6d, 8'h2c, 8'h2e, 8'h2f,
        8'h00, 8'h00, 8'h00, 8'h20};

    localparam logic [CHAR_W-1:0] UPPER_MAP [KEY_SPAN] = '{
        8'h00, 8'h00, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5e, 8'h26, 8'h2a,
        8'h28, 8'h29, 8'h5f, 8'h2b, 8'h00, 8'h00,
        8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49, 8'h4f, 8'h50,
        8'h7b, 8'h7d, 8'h0a, 8'h00,
        8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4a, 8'h4b, 8'h4c, 8'h3a,
        8'h22, 8'h7e, 8'h00, 8'h7c,
        8'h5a, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4e, 8'h4d, 8'h3c, 8'h3e, 8'h3f,
        8'h00, 8'h00, 8'h00, 8'h20};

    localparam logic [CHAR_W-1:0] CTRL_MAP [KEY_SPAN] = '{
        8'h00, 8'h00, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38,
        8'h39, 8'h30, 8'h2d, 8'h3d, 8'h00, 8'h00,
        8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49, 8'h4f, 8'h50,
        8'h5b, 8'h5d, 8'h0a, 8'h00,
        8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4a, 8'h4b, 8'h4c, 8'h3b,
        8'h27, 8'h60, 8'h00, 8'h5c,
        8'h5a, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4e, 8'h4d, 8'h2c, 8'h2e, 8'h2f,
        8'h00, 8'h00, 8'h00, 8'h20};

    // work handed from the decode side to the line side
    typedef enum logic [2:0] {
        CMD_STATUS,
        CMD_READ,
        CMD_CLEAR,
        CMD_BKSP,
        CMD_APPEND1,
        CMD_APPEND2
    } t_cmd_op;

    typedef struct packed {
        t_cmd_op            op;
        logic [CHAR_W-1:0]  c0;
        logic [CHAR_W-1:0]  c1;
        logic [IDX_W-1:0]   idx;
    } t_cmd;

    // codes above the table span map to zero
    function automatic logic [CHAR_W-1:0] map_key(input logic [SC_W-1:0] sc,
                                                  input logic [1:0] sel);
        logic [5:0]        k;
        logic [CHAR_W-1:0] c;
        k = sc[5:0];
        c = '0;
        if (sc < SC_W'(KEY_SPAN)) begin
            case (sel)
                MAP_PLAIN: c = PLAIN_MAP[k];
                MAP_UPPER: c = UPPER_MAP[k];
                MAP_CTRL:  c = CTRL_MAP[k];
                default:   c = '0;
            endcase
        end
        return c;
    endfunction

endpackage

// ===== rtl/ksle_if.sv =====
// ----------------------------------------------------------------------------
// ksle channel interfaces
// valid/ready channels for key items and result items
// ----------------------------------------------------------------------------
interface ksle_key_if
    import ksle_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    op;
    logic [SC_W-1:0]    scancode;
    logic [IDX_W-1:0]   read_index;

    modport source (output valid, output op, output scancode, output read_index,
                    input ready);
    modport sink   (input valid, input op, input scancode, input read_index,
                    output ready);
endinterface

interface ksle_res_if
    import ksle_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [KIND_W-1:0]  kind;
    logic [CHAR_W-1:0]  char_code;
    logic [LEN_W-1:0]   line_length;
    logic               last;

    modport source (output valid, output kind, output char_code, output line_length,
                    output last, input ready);
    modport sink   (input valid, input kind, input char_code, input line_length,
                    input last, output ready);
endinterface

// ===== rtl/ksle_front.sv =====
// ----------------------------------------------------------------------------
// ksle_front
// accepts key items, tracks modifier keys and turns each item into a command
// ----------------------------------------------------------------------------
module ksle_front
    import ksle_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    ksle_key_if.sink    i_key,
    input  logic        i_q_full,
    output logic        o_push,
    output t_cmd        o_cmd
);

    logic r_caps, r_shift, r_ctrl;
    logic n_caps, n_shift, n_ctrl;
    t_cmd cmd;

    assign i_key.ready = !i_q_full;
    assign o_push      = i_key.valid && !i_q_full;
    assign o_cmd       = cmd;

    always_comb begin
        n_caps   = r_caps;
        n_shift  = r_shift;
        n_ctrl   = r_ctrl;
        cmd.op   = CMD_STATUS;
        cmd.c0   = '0;
        cmd.c1   = '0;
        cmd.idx  = i_key.read_index;
        case (i_key.op)
            OP_READ:  cmd.op = CMD_READ;
            OP_CLEAR: cmd.op = CMD_CLEAR;
            OP_SCAN: begin
                if (!i_key.scancode[RELEASE_BIT]) begin
                    if (i_key.scancode == SC_BACKSPACE) begin
                        cmd.op = CMD_BKSP;
                    end else if (i_key.scancode == SC_CAPS) begin
                        n_caps = !r_caps;
                    end else if (i_key.scancode == SC_LSHIFT ||
                                 i_key.scancode == SC_RSHIFT) begin
                        n_shift = 1'b1;
                    end else if (i_key.scancode == SC_CTRL) begin
                        n_ctrl = 1'b1;
                    end else if (i_key.scancode == SC_ENTER) begin
                        cmd.op = CMD_APPEND1;
                        cmd.c0 = CH_NEWLINE;
                    end else if (r_ctrl) begin
                        // caret first, then the ctrl table character
                        cmd.op = CMD_APPEND2;
                        cmd.c0 = CH_CARET;
                        cmd.c1 = map_key(i_key.scancode, MAP_CTRL);
                        n_ctrl = 1'b0;
                    end else begin
                        cmd.op = CMD_APPEND1;
                        if (r_shift) begin
                            cmd.c0  = map_key(i_key.scancode, MAP_UPPER);
                            n_shift = 1'b0;
                        end else if (r_caps) begin
                            cmd.c0 = map_key(i_key.scancode, MAP_UPPER);
                        end else begin
                            cmd.c0 = map_key(i_key.scancode, MAP_PLAIN);
                        end
                    end
                end
            end
            default: cmd.op = CMD_STATUS;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_caps  <= 1'b0;
            r_shift <= 1'b0;
            r_ctrl  <= 1'b0;
        end else if (o_push) begin
            r_caps  <= n_caps;
            r_shift <= n_shift;
            r_ctrl  <= n_ctrl;
        end
    end

endmodule

// ===== rtl/ksle_queue.sv =====
// ----------------------------------------------------------------------------
// ksle_queue
// two-entry command queue between the decode side and the line side
// ----------------------------------------------------------------------------
module ksle_queue
    import ksle_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_cmd    i_cmd,
    output logic    o_full,
    output logic    o_valid,
    output t_cmd    o_cmd,
    input  logic    i_pop
);

    t_cmd       r_slot [2];
    logic       r_wr_ptr, r_rd_ptr;
    logic [1:0] r_count;
    logic       do_push, do_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_cmd   = r_slot[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== rtl/ksle_back.sv =====
// ----------------------------------------------------------------------------
// ksle_back
// runs commands against the line store and fill count, drives the results
// ----------------------------------------------------------------------------
module ksle_back
    import ksle_pkg::*;
#(
    parameter int LINE_DEPTH = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_valid,
    input  t_cmd        i_q_cmd,
    output logic        o_pop,
    ksle_res_if.source  o_res
);

    localparam int AW = $clog2(LINE_DEPTH);
    localparam int FW = $clog2(LINE_DEPTH + 1);
    localparam int CW = (FW > IDX_W) ? FW : IDX_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_WR2,
        S_OUT0,
        S_OUT1
    } t_state;

    t_state              r_state;
    t_cmd                r_cmd;
    logic [FW-1:0]       r_fill;
    logic                r_erase;
    logic                r_out_valid;
    logic [KIND_W-1:0]   r_out_kind;
    logic [CHAR_W-1:0]   r_out_char;
    logic [LEN_W-1:0]    r_out_len;
    logic                r_out_last;

    logic [CHAR_W-1:0]   r_mem [LINE_DEPTH];
    logic [CHAR_W-1:0]   r_rd_data;
    logic                r_rd_hit;

    logic                out_free;
    logic                ok1, ok2;
    logic                mem_we;
    logic [CHAR_W-1:0]   mem_wdata;
    logic [AW-1:0]       mem_waddr;
    logic [AW-1:0]       rd_addr;

    assign out_free = !r_out_valid || o_res.ready;
    assign o_pop    = (r_state == S_IDLE) && i_q_valid;

    // room checks for one byte and for a caret pair
    assign ok1 = (r_cmd.c0 != '0) && (r_fill != FW'(LINE_DEPTH));
    assign ok2 = (r_cmd.c1 != '0) && (r_fill <= FW'(LINE_DEPTH - 2));

    always_comb begin
        mem_we    = 1'b0;
        mem_wdata = r_cmd.c0;
        if (r_state == S_EXEC) begin
            mem_we = ((r_cmd.op == CMD_APPEND1) && ok1) ||
                     ((r_cmd.op == CMD_APPEND2) && ok2);
        end else if (r_state == S_WR2) begin
            mem_we    = 1'b1;
            mem_wdata = r_cmd.c1;
        end
    end

    assign mem_waddr = AW'(r_fill);
    assign rd_addr   = AW'(r_cmd.idx);

    // entries at or past the fill count read as zero, so no clearing pass
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_mem[rd_addr];
        r_rd_hit  <= CW'(r_cmd.idx) < CW'(r_fill);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_cmd   <= i_q_cmd;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_state <= S_OUT0;
                    case (r_cmd.op)
                        CMD_CLEAR: r_fill <= '0;
                        CMD_BKSP: begin
                            r_erase <= (r_fill != '0);
                            if (r_fill != '0) begin
                                r_fill <= r_fill - FW'(1);
                            end
                        end
                        CMD_APPEND1: begin
                            r_fill <= ok1 ? r_fill + FW'(1) : '0;
                        end
                        CMD_APPEND2: begin
                            if (ok2) begin
                                r_fill  <= r_fill + FW'(1);
                                r_state <= S_WR2;
                            end else begin
                                r_fill <= '0;
                            end
                        end
                        default: r_fill <= r_fill;
                    endcase
                end
                S_WR2: begin
                    r_fill  <= r_fill + FW'(1);
                    r_state <= S_OUT0;
                end
                S_OUT0: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_last  <= 1'b1;
                        r_out_kind  <= KIND_STATUS;
                        r_out_char  <= '0;
                        r_out_len   <= LEN_W'(r_fill);
                        r_state     <= S_IDLE;
                        case (r_cmd.op)
                            CMD_READ: begin
                                r_out_char <= r_rd_hit ? r_rd_data : '0;
                            end
                            CMD_BKSP: begin
                                r_out_kind <= r_erase ? KIND_ERASE : KIND_STATUS;
                            end
                            CMD_APPEND1: begin
                                if (r_cmd.c0 != '0) begin
                                    r_out_kind <= KIND_ECHO;
                                    r_out_char <= r_cmd.c0;
                                end
                            end
                            CMD_APPEND2: begin
                                r_out_kind <= KIND_ECHO;
                                r_out_char <= r_cmd.c0;
                                r_out_last <= 1'b0;
                                r_state    <= S_OUT1;
                            end
                            default: r_out_kind <= KIND_STATUS;
                        endcase
                    end
                end
                S_OUT1: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_last  <= 1'b1;
                        r_out_kind  <= (r_cmd.c1 != '0) ? KIND_ECHO : KIND_STATUS;
                        r_out_char  <= r_cmd.c1;
                        r_out_len   <= LEN_W'(r_fill);
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.kind        = r_out_kind;
    assign o_res.char_code   = r_out_char;
    assign o_res.line_length = r_out_len;
    assign o_res.last        = r_out_last;

endmodule

// ===== rtl/keyboard_scancode_line_editor_core.sv =====
// ----------------------------------------------------------------------------
// keyboard_scancode_line_editor_core
// set 1 scancode decoder with an editable line buffer
// ----------------------------------------------------------------------------
//
//  channel   dir   payload                                   transfer when
//  -------   ---   ---------------------------------------   ----------------
//  i_key     in    op, scancode, read_index                  valid && ready
//  o_res     out   kind, char_code, line_length, last        valid && ready
//
//  an item passes through the line side in steps: queue pop, execute, a second
//  store write for a ctrl pair, then one or two results; the single
//  write port of the line store and the result register set these steps
//  the decode side takes an item per cycle until the two-entry queue is full
//  reset is synchronous and clears flags, fill count, queue and result valid;
//  the line store holds no reset, entries past the fill count read as zero
//  a stalled result holds the line side, the decode side keeps taking until the queue is full
//
module keyboard_scancode_line_editor_core
    import ksle_pkg::*;
#(
    parameter int LINE_DEPTH = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ksle_key_if.sink    i_key,
    ksle_res_if.source  o_res
);

    // front to queue
    logic   push;
    t_cmd   push_cmd;
    logic   q_full;

    // queue to back
    logic   q_valid;
    t_cmd   q_cmd;
    logic   pop;

    // decode, modifier tracking and table lookup
    ksle_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_key    (i_key),
        .i_q_full (q_full),
        .o_push   (push),
        .o_cmd    (push_cmd)
    );

    // decouples key intake from line edits and result stalls
    ksle_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (q_cmd),
        .i_pop   (pop)
    );

    // line store, fill count and result register
    ksle_back #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_cmd   (q_cmd),
        .o_pop     (pop),
        .o_res     (o_res)
    );

endmodule

// ===== rtl/ksle_checker.sv =====
// ----------------------------------------------------------------------------
// ksle_checker
// port-level checks on the result channel of the line editor
// ----------------------------------------------------------------------------
`include "keyboard_scancode_line_editor_core_macros.svh"

module ksle_checker
    import ksle_pkg::*;
#(
    parameter int LINE_DEPTH = 1024
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_res_valid,
    input  logic                i_res_ready,
    input  logic [KIND_W-1:0]   i_res_kind,
    input  logic [CHAR_W-1:0]   i_res_char,
    input  logic [LEN_W-1:0]    i_res_len,
    input  logic                i_res_last
);

    `KSLE_ASSERT_NEXT(a_res_hold, i_res_valid && !i_res_ready, i_res_valid && $stable(i_res_kind) && $stable(i_res_char) && $stable(i_res_len) && $stable(i_res_last), "result changed while stalled")

    `KSLE_ASSERT_NOW(a_len_bound, i_res_valid && LINE_DEPTH < 2048, i_res_len <= LEN_W'(LINE_DEPTH), "line length beyond capacity")

    `KSLE_ASSERT_NOW(a_erase_form, i_res_valid && i_res_kind == KIND_ERASE, i_res_last && i_res_char == '0, "erase result malformed")

    `KSLE_ASSERT_NOW(a_first_of_pair, i_res_valid && !i_res_last, i_res_kind == KIND_ECHO && i_res_char == CH_CARET, "non-final result is not a caret echo")

endmodule

bind keyboard_scancode_line_editor_core ksle_checker #(
    .LINE_DEPTH (LINE_DEPTH)
) u_ksle_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_res_kind  (o_res.kind),
    .i_res_char  (o_res.char_code),
    .i_res_len   (o_res.line_length),
    .i_res_last  (o_res.last)
);
